// File: hw/rtl/tmp_pkg.sv
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types and constants for the trapezoidal motion profile generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmp_pkg;

  localparam int FRAC_BITS  = 32;
  localparam int TICK_WIDTH = 32;
  localparam int NUM_SHIFT  = FRAC_BITS - 16;

  // Ticks before saturation; ceilings reach up to 33 bits.
  localparam int TW_EXT = 33;
  localparam logic [TW_EXT-1:0] TICK_MAX = TW_EXT'((64'd1 << TICK_WIDTH) - 64'd1);

  // Ramp root search bounds.
  localparam logic [15:0] SRCH_LO = 16'd1;
  localparam logic [15:0] SRCH_HI = 16'd65535;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    MS_MIDSQ  = 3'd0,
    MS_ACC    = 3'd1,
    MS_T1ACC  = 3'd2,
    MS_PRODT1 = 3'd3,
    MS_DENOM  = 3'd4
  } mul_src_t;

  typedef enum logic [1:0] {
    DS_T1   = 2'd0,
    DS_T2   = 2'd1,
    DS_AMAG = 2'd2
  } div_src_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH_CHK,
    S_SQ_LO,
    S_SQ_HI,
    S_SA_LO,
    S_SA_HI,
    S_SRCH_UPD,
    S_VT_LO,
    S_VT_HI,
    S_VCHK,
    S_D1_RUN,
    S_D1_END,
    S_C1_LO,
    S_C1_HI,
    S_C2_LO,
    S_C2_HI,
    S_CCHK,
    S_D2_RUN,
    S_D2_END,
    S_SAT,
    S_DEN_LO,
    S_DEN_HI,
    S_D3_RUN,
    S_D3_END,
    S_TK_V,
    S_TK_P
  } state_t;

  typedef struct packed {
    logic     start_load;
    logic     srch_mid;
    logic     srch_upd;
    logic     t1_from_lo;
    logic     mul_lo;
    logic     mul_hi;
    mul_src_t mul_sel;
    logic     div_load;
    div_src_t div_sel;
    logic     div_step;
    logic     t1_from_quo;
    logic     t2_from_quo;
    logic     sat;
    logic     finish;
    logic     tick_v;
    logic     tick_p;
    phase_t   phase;
  } cmd_t;

  typedef struct packed {
    logic zero_in;
    logic lo_lt_hi;
    logic vmax_lt_prod;
    logic mag_gt_prod;
    logic div_last;
    logic tick_done;
    logic cruise_nz;
  } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/trapezoid_motion_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_motion_profile
// Single-axis trapezoidal velocity profile: plans a move, then emits one
// acceleration/velocity/position word per servo tick.
// ----------------------------------------------------------------------------
//  channel  ports                                         direction
//  in       in_valid/in_stall, operation, distance,       into block
//           max_velocity, accel_limit
//  out      out_valid/out_stall, accel_out, velocity_out, out of block
//           position_out, last_tick
//
//  A start word with any operand zero returns straight to idle; otherwise
//  up to 16 root-search iterations, up to three bit-serial divider runs
//  (64 steps and a writeback) and a handful of multiplies, each a low half
//  and a high half on the shared multiplier.
//  A tick word runs accept, velocity add, then position add and output.
//  Synchronous active-low reset returns the block to idle with no move.
//  The input is taken only while the sequencer is idle; a result held by
//  out_stall lets the next word in, but that tick then waits at the position
//  update and holds in_stall high until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_motion_profile import tmp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic signed [31:0] in_distance,
  input  wire logic [31:0] in_max_velocity,
  input  wire logic [31:0] in_accel_limit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [63:0] out_accel_out,
  output logic signed [63:0] out_velocity_out,
  output logic signed [63:0] out_position_out,
  output logic             out_last_tick
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: root search, ceilings, refit and per-tick phase stepping.
  tmp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Arithmetic and move state.
  tmp_dp u_dp (
    .clk              (clk),
    .in_distance      (in_distance),
    .in_max_velocity  (in_max_velocity),
    .in_accel_limit   (in_accel_limit),
    .cmd              (cmd),
    .stat             (stat),
    .out_accel_out    (out_accel_out),
    .out_velocity_out (out_velocity_out),
    .out_position_out (out_position_out),
    .out_last_tick    (out_last_tick)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tmp_dp.sv
// ----------------------------------------------------------------------------
// tmp_dp
// Datapath: shared multiplier, restoring divider, profile and tick state.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_dp import tmp_pkg::*; (
  input  wire logic        clk,
  input  wire logic [31:0] in_distance,
  input  wire logic [31:0] in_max_velocity,
  input  wire logic [31:0] in_accel_limit,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  output logic [63:0]      out_accel_out,
  output logic [63:0]      out_velocity_out,
  output logic [63:0]      out_position_out,
  output logic             out_last_tick
);

  logic [31:0] mag_r, vmax_r, acc_r;
  logic        neg_r;
  logic [15:0] lo_r, hi_r, mid_r;
  logic [TW_EXT-1:0] t1_r, t2_r;
  logic [63:0] prod_r;
  logic [31:0] mhi_r;
  logic [31:0] mb_r;
  logic [63:0] rem_r, quo_r, dvs_r;
  logic [5:0]  dcnt_r;
  logic [TICK_WIDTH-1:0] ramp_r, cruise_r, tcnt_r;
  logic [63:0] step_r, vel_r, pos_r;
  logic [63:0] oacc_r, ovel_r, opos_r;
  logic        olast_r;

  logic [16:0] mid_sum;
  logic [63:0] mul_a;
  logic [31:0] mul_b, mx, my;
  logic [63:0] mprod;
  logic [63:0] dvd, dvs_sel;
  logic [64:0] rem_sh, rem_sub;
  logic [63:0] ax;
  logic [TICK_WIDTH-1:0] len;
  logic [63:0] den_sum;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign den_sum = 64'(t1_r) + 64'(t2_r);

  always_comb begin
    case (cmd.mul_sel)
      MS_MIDSQ: begin
        mul_a = 64'(mid_r);
        mul_b = 32'(mid_r);
      end
      MS_ACC: begin
        mul_a = prod_r;
        mul_b = acc_r;
      end
      MS_T1ACC: begin
        mul_a = 64'(t1_r);
        mul_b = acc_r;
      end
      MS_PRODT1: begin
        mul_a = prod_r;
        mul_b = t1_r[31:0];
      end
      MS_DENOM: begin
        mul_a = den_sum;
        mul_b = t1_r[31:0];
      end
      default: begin
        mul_a = 64'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // One 32x32 multiplier, low half then high half.
  assign mx    = cmd.mul_hi ? mhi_r : mul_a[31:0];
  assign my    = cmd.mul_hi ? mb_r : mul_b;
  assign mprod = 64'(mx) * 64'(my);

  always_comb begin
    case (cmd.div_sel)
      DS_T1: begin
        dvd     = 64'(vmax_r) + 64'(acc_r) - 64'd1;
        dvs_sel = 64'(acc_r);
      end
      DS_T2: begin
        dvd     = 64'(mag_r) - prod_r + 64'(vmax_r) - 64'd1;
        dvs_sel = 64'(vmax_r);
      end
      DS_AMAG: begin
        dvd     = (64'(mag_r) << NUM_SHIFT) + (prod_r >> 1);
        dvs_sel = prod_r;
      end
      default: begin
        dvd     = 64'd0;
        dvs_sel = 64'd1;
      end
    endcase
  end

  assign rem_sh  = {rem_r, quo_r[63]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    case (cmd.phase)
      PH_ACCEL: begin
        ax  = step_r;
        len = ramp_r;
      end
      PH_CRUISE: begin
        ax  = 64'd0;
        len = cruise_r;
      end
      PH_DECEL: begin
        ax  = 64'd0 - step_r;
        len = ramp_r;
      end
      default: begin
        ax  = 64'd0;
        len = ramp_r;
      end
    endcase
  end

  assign stat.zero_in      = (in_distance == 32'd0) || (in_max_velocity == 32'd0) ||
                             (in_accel_limit == 32'd0);
  assign stat.lo_lt_hi     = lo_r < hi_r;
  assign stat.vmax_lt_prod = 64'(vmax_r) < prod_r;
  assign stat.mag_gt_prod  = 64'(mag_r) > prod_r;
  assign stat.div_last     = dcnt_r == 6'd63;
  assign stat.tick_done    = tcnt_r >= len;
  assign stat.cruise_nz    = cruise_r != '0;

  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      neg_r    <= in_distance[31];
      mag_r    <= in_distance[31] ? (~in_distance + 32'd1) : in_distance;
      vmax_r   <= in_max_velocity;
      acc_r    <= in_accel_limit;
      lo_r     <= SRCH_LO;
      hi_r     <= SRCH_HI;
      t2_r     <= '0;
      ramp_r   <= '0;
      cruise_r <= '0;
      tcnt_r   <= '0;
      step_r   <= 64'd0;
      vel_r    <= 64'd0;
      pos_r    <= 64'd0;
    end
    if (cmd.srch_mid) mid_r <= mid_sum[16:1];
    if (cmd.srch_upd) begin
      if (prod_r >= 64'(mag_r)) hi_r <= mid_r;
      else lo_r <= mid_r + 16'd1;
    end
    if (cmd.t1_from_lo) t1_r <= TW_EXT'(lo_r);
    if (cmd.mul_lo) begin
      prod_r <= mprod;
      mhi_r  <= mul_a[63:32];
      mb_r   <= mul_b;
    end
    if (cmd.mul_hi) prod_r <= prod_r + {mprod[31:0], 32'd0};
    if (cmd.div_load) begin
      rem_r  <= 64'd0;
      quo_r  <= dvd;
      dvs_r  <= dvs_sel;
      dcnt_r <= 6'd0;
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 6'd1;
      if (!rem_sub[64]) begin
        rem_r <= rem_sub[63:0];
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh[63:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
    if (cmd.t1_from_quo) t1_r <= quo_r[TW_EXT-1:0];
    if (cmd.t2_from_quo) t2_r <= quo_r[TW_EXT-1:0];
    if (cmd.sat) begin
      t1_r <= (t1_r > TICK_MAX) ? TICK_MAX : t1_r;
      t2_r <= (t2_r > TICK_MAX) ? TICK_MAX : t2_r;
    end
    if (cmd.finish) begin
      ramp_r   <= t1_r[TICK_WIDTH-1:0];
      cruise_r <= t2_r[TICK_WIDTH-1:0];
      step_r   <= neg_r ? (64'd0 - quo_r) : quo_r;
    end
    if (cmd.tick_v) begin
      vel_r  <= vel_r + ax;
      tcnt_r <= tcnt_r + TICK_WIDTH'(1);
    end
    if (cmd.tick_p) begin
      pos_r   <= pos_r + vel_r;
      oacc_r  <= ax;
      ovel_r  <= vel_r;
      opos_r  <= pos_r + vel_r;
      olast_r <= stat.tick_done && (cmd.phase == PH_DECEL);
      if (stat.tick_done) tcnt_r <= '0;
    end
  end

  assign out_accel_out    = oacc_r;
  assign out_velocity_out = ovel_r;
  assign out_position_out = opos_r;
  assign out_last_tick    = olast_r;

endmodule

`default_nettype wire

// File: hw/rtl/tmp_ctrl.sv
// ----------------------------------------------------------------------------
// tmp_ctrl
// Sequencer for move planning and servo ticks; owns phase and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_ctrl import tmp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic in_operation,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire stat_t stat,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   out_free;

  assign out_free  = !ovalid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd        = '0;
    cmd.phase  = phase_r;
    cmd.mul_sel = MS_MIDSQ;
    cmd.div_sel = DS_T1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_START) begin
            cmd.start_load = 1'b1;
            phase_nxt      = PH_IDLE;
            if (!stat.zero_in) state_nxt = S_SRCH_CHK;
          end else if (phase_r != PH_IDLE) begin
            state_nxt = S_TK_V;
          end
        end
      end
      S_SRCH_CHK: begin
        if (stat.lo_lt_hi) begin
          cmd.srch_mid = 1'b1;
          state_nxt    = S_SQ_LO;
        end else begin
          cmd.t1_from_lo = 1'b1;
          state_nxt      = S_VT_LO;
        end
      end
      S_SQ_LO: begin
        cmd.mul_sel = MS_MIDSQ;
        cmd.mul_lo  = 1'b1;
        state_nxt   = S_SQ_HI;
      end
      S_SQ_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_SA_LO;
      end
      S_SA_LO: begin
        cmd.mul_sel = MS_ACC;
        cmd.mul_lo  = 1'b1;
        state_nxt   = S_SA_HI;
      end
      S_SA_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_SRCH_UPD;
      end
      S_SRCH_UPD: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRCH_CHK;
      end
      S_VT_LO: begin
        cmd.mul_sel = MS_T1ACC;
        cmd.mul_lo  = 1'b1;
        state_nxt   = S_VT_HI;
      end
      S_VT_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_VCHK;
      end
      S_VCHK: begin
        if (stat.vmax_lt_prod) begin
          cmd.div_sel  = DS_T1;
          cmd.div_load = 1'b1;
          state_nxt    = S_D1_RUN;
        end else begin
          state_nxt = S_SAT;
        end
      end
      S_D1_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_D1_END;
      end
      S_D1_END: begin
        cmd.t1_from_quo = 1'b1;
        state_nxt       = S_C1_LO;
      end
      S_C1_LO: begin
        cmd.mul_sel = MS_T1ACC;
        cmd.mul_lo  = 1'b1;
        state_nxt   = S_C1_HI;
      end
      S_C1_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_C2_LO;
      end
      S_C2_LO: begin
        cmd.mul_sel = MS_PRODT1;
        cmd.mul_lo  = 1'b1;
        state_nxt   = S_C2_HI;
      end
      S_C2_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_CCHK;
      end
      S_CCHK: begin
        // Cruise only when the ramps leave distance uncovered.
        if (stat.mag_gt_prod) begin
          cmd.div_sel  = DS_T2;
          cmd.div_load = 1'b1;
          state_nxt    = S_D2_RUN;
        end else begin
          state_nxt = S_SAT;
        end
      end
      S_D2_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_D2_END;
      end
      S_D2_END: begin
        cmd.t2_from_quo = 1'b1;
        state_nxt       = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_DEN_LO;
      end
      S_DEN_LO: begin
        cmd.mul_sel = MS_DENOM;
        cmd.mul_lo  = 1'b1;
        state_nxt   = S_DEN_HI;
      end
      S_DEN_HI: begin
        // Load the refit divider on the way out of the denominator multiply;
        // the divider samples the product after the low pass only, so t1 + t2 must stay below 2^32.
        cmd.mul_hi   = 1'b1;
        cmd.div_sel  = DS_AMAG;
        cmd.div_load = 1'b1;
        state_nxt    = S_D3_RUN;
      end
      S_D3_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_D3_END;
      end
      S_D3_END: begin
        cmd.finish = 1'b1;
        phase_nxt  = PH_ACCEL;
        state_nxt  = S_IDLE;
      end
      S_TK_V: begin
        cmd.tick_v = 1'b1;
        state_nxt  = S_TK_P;
      end
      S_TK_P: begin
        // Hold until the output register is free.
        if (out_free) begin
          cmd.tick_p = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
          if (stat.tick_done) begin
            case (phase_r)
              PH_ACCEL:  phase_nxt = stat.cruise_nz ? PH_CRUISE : PH_DECEL;
              PH_CRUISE: phase_nxt = PH_DECEL;
              PH_DECEL:  phase_nxt = PH_IDLE;
              default:   phase_nxt = PH_IDLE;
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
